>>> rtl/core/assert_macros.svh
// Assertion macros shared by the tableau pivot RTL.
// Both macros sample on clk and are disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define STP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent this cycle, consequent the next cycle.
`define STP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/stp_pkg.sv
// Package for the simplex tableau pivot block: sizes, codes, payload types.
// No dependencies; used by every module under rtl/core.
package stp_pkg;

  localparam int DIM       = 32;
  localparam int IDX_W     = $clog2(DIM);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int STEP_W    = $clog2(NUM_W + 1);
  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_PIVOT = 2'd1;

  // mark codes
  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_P1     = 2'd1;
  localparam logic [1:0] MARK_P1_DEM = 2'd2;
  localparam logic [1:0] MARK_P2     = 2'd3;

  // register indexes
  localparam logic [1:0] REG_NUM_COLS  = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS  = 2'd1;
  localparam logic [1:0] REG_PIVOT_EPS = 2'd2;

  typedef struct packed {
    logic [1:0]               cmd;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } stp_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               mark;
    logic                     status;
  } stp_rsp_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLEAR, OP_READ, OP_WRITE, OP_LATCH_M, OP_LATCH_RHS,
    OP_MUL, OP_RND, OP_ELIM, OP_LOAD, OP_SHIFT, OP_MARK
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         addr;
    logic [IDX_W-1:0]         row;
    logic [CNT_W-1:0]         nrows;
    logic                     zero_col;
    logic                     phase1;
    logic                     mixed;
    logic signed [DATA_W-1:0] wdata;
  } cell_ctl_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WR,
    S_PV_RD, S_PV_CHK, S_PV_COLRD, S_PV_DIVGO, S_PV_DIV, S_PV_MUL, S_PV_RND, S_PV_ELIM,
    S_RC_RHS, S_RC_LATCH, S_ST_RD, S_ST_EV, S_FIRST, S_TOP_RD, S_TOP_EV,
    S_CL_RD, S_CL_EV, S_RT_MUL, S_RT_CMP, S_TI_RD, S_TI_LD, S_MK_WR,
    S_FIN_RD, S_FIN_OUT
  } stp_state_t;

endpackage

>>> rtl/core/simplex_tableau_pivot.sv
// Top level of the simplex tableau pivot block: controller, registers, row cells, divider.
// Depends on stp_pkg, stp_cell, stp_div and assert_macros.svh.
`include "assert_macros.svh"
//
//  channel   ports                           handshake
//  -------   -----------------------------   ------------------------------------
//  command   start, busy, req                taken at start && !busy
//  result    done, rsp                       one cycle on done, cannot be held off
//  config    psel penable pwrite paddr ...   APB, written at psel&penable&pwrite
//
// After reset a pass clears every row memory; busy stays high meanwhile.
// Read: result read-out only. Write: entry write, then recompute. Refused
// pivot: element read and check, then read-out. Pivot: one column pass per
// column, one more when the pivot column lies at or beyond nc, then recompute.
// Recompute: star and top scans, plus a ratio scan per candidate column; the
// ratio scan streams rows through the cell chain and is the dominant term,
// next to the bit-serial divider (one quotient bit a cycle).
// A new command is taken in the cycle the result strobe is up.
module simplex_tableau_pivot import stp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  stp_req_t    req,
  output logic        done,
  output stp_rsp_t    rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  stp_state_t state, state_next;

  // configuration registers
  logic [5:0]  num_cols, num_rows;
  logic [16:0] pivot_eps;

  // transaction registers
  logic [1:0]               cmd_q;
  logic [IDX_W-1:0]         row_q, col_q;
  logic signed [DATA_W-1:0] val_q;
  logic                     status_q;

  // sequencing and mark search
  logic [CNT_W-1:0]           i, k;
  logic [DIM-1:0]             starred, tied;
  logic [IDX_W-1:0]           first;
  logic signed [DATA_W-1:0]   top, bestv, bestrhs, q_reg;
  logic signed [2*DATA_W-1:0] pa, pb;
  logic                       phase1, found, tie_pass;

  // cell array
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] rdata_a [DIM];
  logic [1:0]               mkrd_a  [DIM];
  logic signed [DATA_W-1:0] shv_a   [DIM];
  logic signed [DATA_W-1:0] shr_a   [DIM];

  // divider; pval is the pivot element, held from the check cycle
  logic                     div_start, div_busy, div_done;
  logic signed [DATA_W-1:0] div_q;
  logic signed [DATA_W-1:0] pval;

  // effective dimensions
  logic [CNT_W-1:0] nc, nr, ncon, nvar;
  logic [IDX_W-1:0] rhs_col;

  always_comb begin
    nc      = (num_cols < 6'd3) ? CNT_W'(3) : (num_cols > 6'(DIM)) ? CNT_W'(DIM) : num_cols;
    nr      = (num_rows < 6'd2) ? CNT_W'(2) : (num_rows > 6'(DIM)) ? CNT_W'(DIM) : num_rows;
    ncon    = nr - 1'b1;
    nvar    = nc - CNT_W'(2);
    rhs_col = IDX_W'(nc - 1'b1);
  end

  logic signed [DATA_W-1:0] rd_row, rd_first, rd_obj, v0, r0;
  logic [DATA_W-1:0]        piv_mag;
  logic                     cand, upd, star_hit, mixed, pv_more;
  logic [DIM-1:0]           nzv, negv;
  logic [IDX_W-1:0]         first_enc;

  assign rd_row   = rdata_a[row_q];
  assign rd_first = rdata_a[first];
  assign rd_obj   = rdata_a[ncon[IDX_W-1:0]];
  assign v0       = shv_a[0];
  assign r0       = shr_a[0];
  assign piv_mag  = rd_row[DATA_W-1] ? (~rd_row + 1'b1) : rd_row;
  assign mixed    = (|(tied & starred)) && (|(tied & ~starred));

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      nzv[j]  = (rdata_a[j] != '0) && (CNT_W'(j) < ncon);
      negv[j] = rdata_a[j][DATA_W-1] && (CNT_W'(j) < ncon);
    end
    // exactly one nonzero constraint entry, and it is negative
    star_hit  = (nzv != '0) && ((nzv & (nzv - 1'b1)) == '0) && ((nzv & negv) != '0);
    first_enc = '0;
    for (int j = DIM - 1; j >= 0; j--) begin
      if (starred[j]) first_enc = IDX_W'(j);
    end
    cand = (i < nvar) && (phase1 ? ((top > 0) && (rd_first == top)) : (rd_obj < 0));
    upd  = !tie_pass && (v0 > 0) && (!found || (pa < pb));
    // a pivot column at or beyond nc still gets its one / zero pass
    pv_more = ((i + 1'b1) < nc) || (({1'b0, col_q} >= nc) && (i != {1'b0, col_q}));
  end

  // next state and cell control
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    ctl.op       = OP_NOP;
    ctl.addr     = i[IDX_W-1:0];
    ctl.row      = row_q;
    ctl.nrows    = nr;
    ctl.zero_col = (i[IDX_W-1:0] == col_q);
    ctl.phase1   = phase1;
    ctl.mixed    = mixed;
    ctl.wdata    = q_reg;
    unique case (state)
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (i == CNT_W'(DIM - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (req.cmd == CMD_WRITE) begin
            state_next = S_WR;
          end else if (req.cmd == CMD_PIVOT) begin
            state_next = S_PV_RD;
          end else begin
            state_next = S_FIN_RD;
          end
        end
      end
      S_WR: begin
        ctl.op     = OP_WRITE;
        ctl.addr   = col_q;
        ctl.wdata  = val_q;
        state_next = S_RC_RHS;
      end
      S_PV_RD: begin
        ctl.op     = OP_READ;
        ctl.addr   = col_q;
        state_next = S_PV_CHK;
      end
      S_PV_CHK: begin
        ctl.op     = OP_LATCH_M;
        state_next = (piv_mag <= DATA_W'(pivot_eps)) ? S_FIN_RD : S_PV_COLRD;
      end
      S_PV_COLRD: begin
        ctl.op     = OP_READ;
        state_next = S_PV_DIVGO;
      end
      S_PV_DIVGO: begin
        div_start  = 1'b1;
        state_next = S_PV_DIV;
      end
      S_PV_DIV: begin
        if (div_done) state_next = S_PV_MUL;
      end
      S_PV_MUL: begin
        ctl.op     = OP_MUL;
        state_next = S_PV_RND;
      end
      S_PV_RND: begin
        ctl.op     = OP_RND;
        state_next = S_PV_ELIM;
      end
      S_PV_ELIM: begin
        ctl.op     = OP_ELIM;
        state_next = pv_more ? S_PV_COLRD : S_RC_RHS;
      end
      S_RC_RHS: begin
        ctl.op     = OP_READ;
        ctl.addr   = rhs_col;
        state_next = S_RC_LATCH;
      end
      S_RC_LATCH: begin
        ctl.op     = OP_LATCH_RHS;
        state_next = S_ST_RD;
      end
      S_ST_RD: begin
        ctl.op     = OP_READ;
        state_next = S_ST_EV;
      end
      S_ST_EV: begin
        state_next = ((i + 1'b1) < nvar) ? S_ST_RD : S_FIRST;
      end
      S_FIRST: begin
        state_next = (starred != '0) ? S_TOP_RD : S_CL_RD;
      end
      S_TOP_RD: begin
        ctl.op     = OP_READ;
        state_next = S_TOP_EV;
      end
      S_TOP_EV: begin
        state_next = ((i + 1'b1) < nvar) ? S_TOP_RD : S_CL_RD;
      end
      S_CL_RD: begin
        ctl.op     = OP_READ;
        state_next = S_CL_EV;
      end
      S_CL_EV: begin
        ctl.op     = OP_LOAD;
        state_next = cand ? S_RT_MUL : S_MK_WR;
      end
      S_RT_MUL: begin
        state_next = S_RT_CMP;
      end
      S_RT_CMP: begin
        ctl.op = OP_SHIFT;
        if ((k + 1'b1) < ncon) begin
          state_next = S_RT_MUL;
        end else if (!tie_pass && (found || upd)) begin
          state_next = S_TI_RD;
        end else begin
          state_next = S_MK_WR;
        end
      end
      S_TI_RD: begin
        ctl.op     = OP_READ;
        state_next = S_TI_LD;
      end
      S_TI_LD: begin
        ctl.op     = OP_LOAD;
        state_next = S_RT_MUL;
      end
      S_MK_WR: begin
        ctl.op     = OP_MARK;
        state_next = (i == CNT_W'(DIM - 1)) ? S_FIN_RD : S_CL_RD;
      end
      S_FIN_RD: begin
        ctl.op     = OP_READ;
        ctl.addr   = col_q;
        state_next = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // controller datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      i        <= '0;
      done     <= 1'b0;
      status_q <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: i <= i + 1'b1;
        S_IDLE: begin
          if (start) begin
            cmd_q    <= req.cmd;
            row_q    <= req.row;
            col_q    <= req.col;
            val_q    <= req.value;
            status_q <= 1'b0;
          end
        end
        S_PV_CHK: begin
          if (piv_mag <= DATA_W'(pivot_eps)) status_q <= 1'b1;
          i <= '0;
        end
        S_PV_DIV: begin
          if (div_done) q_reg <= (i[IDX_W-1:0] == col_q) ? FX_ONE : div_q;
        end
        S_PV_ELIM: i <= ((i + 1'b1) < nc) ? i + 1'b1 : {1'b0, col_q};
        S_RC_LATCH: begin
          i       <= '0;
          starred <= '0;
        end
        S_ST_EV: begin
          if (star_hit) starred <= starred | nzv;
          i <= i + 1'b1;
        end
        S_FIRST: begin
          first  <= first_enc;
          phase1 <= (starred != '0);
          top    <= '0;
          i      <= '0;
        end
        S_TOP_EV: begin
          if (rd_first > top) top <= rd_first;
          i <= ((i + 1'b1) < nvar) ? i + 1'b1 : '0;
        end
        S_CL_EV: begin
          tied     <= '0;
          k        <= '0;
          found    <= 1'b0;
          tie_pass <= 1'b0;
        end
        S_RT_MUL: begin
          pa <= r0 * bestv;
          pb <= bestrhs * v0;
        end
        S_RT_CMP: begin
          if (upd) begin
            bestv   <= v0;
            bestrhs <= r0;
            found   <= 1'b1;
          end
          if (tie_pass && (v0 > 0) && (pa == pb)) tied[k[IDX_W-1:0]] <= 1'b1;
          k <= k + 1'b1;
        end
        S_TI_LD: begin
          k        <= '0;
          tie_pass <= 1'b1;
        end
        S_MK_WR: i <= i + 1'b1;
        S_FIN_OUT: begin
          done           <= 1'b1;
          rsp.read_value <= rd_row;
          rsp.mark       <= mkrd_a[row_q];
          rsp.status     <= status_q;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols  <= 6'd18;
      num_rows  <= 6'd9;
      pivot_eps <= 17'd7;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NUM_COLS:  num_cols  <= pwdata[5:0];
        REG_NUM_ROWS:  num_rows  <= pwdata[5:0];
        REG_PIVOT_EPS: pivot_eps <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NUM_COLS:  prdata = {26'd0, num_cols};
      REG_NUM_ROWS:  prdata = {26'd0, num_rows};
      REG_PIVOT_EPS: prdata = {15'd0, pivot_eps};
      default:       prdata = '0;
    endcase
  end

  // row cells, chained for the ratio scan toward cell 0
  for (genvar j = 0; j < DIM; j++) begin : g_cell
    logic signed [DATA_W-1:0] nv, nrh;
    if (j == DIM - 1) begin : g_end
      assign nv  = '0;
      assign nrh = '0;
    end else begin : g_mid
      assign nv  = shv_a[j+1];
      assign nrh = shr_a[j+1];
    end
    stp_cell u_cell (
      .clk    (clk),
      .idx    (IDX_W'(j)),
      .ctl    (ctl),
      .tie    (tied[j]),
      .star   (starred[j]),
      .nxt_v  (nv),
      .nxt_rhs(nrh),
      .rdata  (rdata_a[j]),
      .mkrd   (mkrd_a[j]),
      .sh_v   (shv_a[j]),
      .sh_rhs (shr_a[j])
    );
  end

  always_ff @(posedge clk) begin
    if (state == S_PV_CHK) pval <= rd_row;
  end

  stp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (rd_row),
    .den  (pval),
    .busy (div_busy),
    .done (div_done),
    .quot (div_q)
  );

  `STP_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held past one cycle")
  `STP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left busy low")
  `STP_ASSERT(a_status_pivot, (done && rsp.status) |-> (cmd_q == CMD_PIVOT), "refusal on non-pivot")
  `STP_ASSERT(a_div_idle, (state == S_PV_DIVGO) |-> !div_busy, "divider restarted while running")

endmodule

>>> rtl/core/stp_div.sv
// Radix-2 restoring divider for the pivot row: round(|a|<<FRAC / |p|), signed, saturated.
// Depends on stp_pkg.
module stp_div import stp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     busy,
  output logic                     done,
  output logic signed [DATA_W-1:0] quot
);

  logic              run;
  logic [STEP_W-1:0] cnt;
  logic [NUM_W-1:0]  nq;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dmag;
  logic              neg;
  logic [DATA_W-1:0] amag, pmag;
  logic [DATA_W:0]   rem_s;
  logic              ge;

  assign amag  = num[DATA_W-1] ? (~num + 1'b1) : num;
  assign pmag  = den[DATA_W-1] ? (~den + 1'b1) : den;
  assign rem_s = {rem, nq[NUM_W-1]};
  assign ge    = rem_s >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= STEP_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[DATA_W-1] ^ den[DATA_W-1];
      dmag <= pmag;
      rem  <= '0;
      // numerator carries the half-divisor so the quotient comes out rounded
      nq   <= ({{FRAC_BITS{1'b0}}, amag} << FRAC_BITS) + NUM_W'(pmag >> 1);
    end else if (run) begin
      rem <= ge ? DATA_W'(rem_s - {1'b0, dmag}) : rem_s[DATA_W-1:0];
      nq  <= {nq[NUM_W-2:0], ge};
    end
  end

  always_comb begin
    if (!neg) begin
      quot = (nq > NUM_W'(FX_MAX)) ? FX_MAX : nq[DATA_W-1:0];
    end else begin
      quot = (nq >= NUM_W'(FX_MAX) + NUM_W'(1)) ? FX_MIN : -nq[DATA_W-1:0];
    end
  end

  assign busy = run;

endmodule

>>> rtl/core/stp_cell.sv
// One tableau row: entry and mark memories, elimination datapath, ratio-chain stage.
// Depends on stp_pkg; instantiated once per row by simplex_tableau_pivot.
module stp_cell import stp_pkg::*; (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         idx,
  input  cell_ctl_t                ctl,
  input  logic                     tie,
  input  logic                     star,
  input  logic signed [DATA_W-1:0] nxt_v,
  input  logic signed [DATA_W-1:0] nxt_rhs,
  output logic signed [DATA_W-1:0] rdata,
  output logic [1:0]               mkrd,
  output logic signed [DATA_W-1:0] sh_v,
  output logic signed [DATA_W-1:0] sh_rhs
);

  logic signed [DATA_W-1:0]   mem [DIM];
  logic [1:0]                 mk  [DIM];
  logic signed [DATA_W-1:0]   m;
  logic signed [DATA_W-1:0]   rhs_hold;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [NUM_W:0]      rnd;
  logic [2*DATA_W-1:0]        pmag;
  logic [NUM_W-1:0]           rsh;
  logic signed [NUM_W+1:0]    diff;
  logic signed [DATA_W-1:0]   elim;
  logic [1:0]                 mark_val;
  logic                       own;

  assign own  = (idx == ctl.row);
  assign pmag = prod[2*DATA_W-1] ? (~prod + 1'b1) : prod;
  assign rsh  = NUM_W'((pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  assign diff = (NUM_W+2)'(rdata) - (NUM_W+2)'(rnd);

  always_comb begin
    if (diff > (NUM_W+2)'(FX_MAX)) begin
      elim = FX_MAX;
    end else if (diff < (NUM_W+2)'(FX_MIN)) begin
      elim = FX_MIN;
    end else begin
      elim = diff[DATA_W-1:0];
    end
    if (!tie) begin
      mark_val = MARK_NONE;
    end else if (!ctl.phase1) begin
      mark_val = MARK_P2;
    end else if (ctl.mixed && !star) begin
      mark_val = MARK_P1_DEM;
    end else begin
      mark_val = MARK_P1;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_CLEAR: begin
        mem[ctl.addr] <= '0;
        mk[ctl.addr]  <= MARK_NONE;
      end
      OP_READ: begin
        rdata <= mem[ctl.addr];
        mkrd  <= mk[ctl.addr];
      end
      OP_WRITE: begin
        if (own) mem[ctl.addr] <= ctl.wdata;
      end
      OP_LATCH_M:   m <= rdata;
      OP_LATCH_RHS: rhs_hold <= rdata;
      OP_MUL:       prod <= m * ctl.wdata;
      OP_RND:       rnd <= prod[2*DATA_W-1] ? -$signed({1'b0, rsh}) : $signed({1'b0, rsh});
      OP_ELIM: begin
        if (own) begin
          mem[ctl.addr] <= ctl.wdata;
        end else if ({1'b0, idx} < ctl.nrows) begin
          mem[ctl.addr] <= ctl.zero_col ? '0 : elim;
        end
      end
      OP_LOAD: begin
        sh_v   <= rdata;
        sh_rhs <= rhs_hold;
      end
      OP_SHIFT: begin
        sh_v   <= nxt_v;
        sh_rhs <= nxt_rhs;
      end
      OP_MARK: mk[ctl.addr] <= mark_val;
      default: ;
    endcase
  end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for simplex_tableau_pivot: directed table, then random
// tableau fill / pivot / read sequences under several dimension and epsilon settings.
// Depends on stp_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_top import stp_pkg::*; ();

  // codes not in the package
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int ITEMS = 540;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  stp_req_t    req;
  logic        done;
  stp_rsp_t    rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  simplex_tableau_pivot u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far above the slowest legal run
  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tableau model: its own copy of the array, marks and registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] tab_m [0:1023];
  logic [1:0]         mark_m [0:1023];
  logic [5:0]         cols_reg;
  logic [5:0]         rows_reg;
  logic [16:0]        eps_reg;
  bit                 tied_m [0:31];

  stp_rsp_t expected_rsp_q [$];
  int       fail_cnt;
  int       sent_cnt;

  function automatic int eff_cols();
    int c;
    c = cols_reg;
    if (c < 3) c = 3;
    if (c > DIM) c = DIM;
    return c;
  endfunction

  function automatic int eff_rows();
    int r;
    r = rows_reg;
    if (r < 2) r = 2;
    if (r > DIM) r = DIM;
    return r;
  endfunction

  function automatic longint ent(int r, int c);
    return longint'(tab_m[r*DIM + c]);
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // product back to Q16.16, nearest, ties away from zero
  function automatic longint fx_round_shift(longint x);
    longint unsigned m;
    m = (mag(x) + (64'd1 << (FRAC_BITS-1))) >> FRAC_BITS;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_divide(longint a, longint p);
    longint unsigned n, d, q;
    n = mag(a) << FRAC_BITS;
    d = mag(p);
    q = (n + d/2) / d;
    if (q > (64'd1 << 32)) q = 64'd1 << 32;
    return ((a < 0) != (p < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // rows with positive entry in column i at the minimum rhs/entry ratio -> tied_m
  function automatic bit min_ratio(int i, int ncon, int rhs);
    int  best;
    bit  found;
    longint v;
    best = 0;
    found = 0;
    for (int j = 0; j < ncon; j++) begin
      v = ent(j, i);
      tied_m[j] = 0;
      if (v > 0 && (!found || ent(j, rhs)*ent(best, i) < ent(best, rhs)*v)) begin
        best = j;
        found = 1;
      end
    end
    if (!found) return 0;
    for (int j = 0; j < ncon; j++) begin
      v = ent(j, i);
      if (v > 0 && ent(j, rhs)*ent(best, i) == ent(best, rhs)*v) tied_m[j] = 1;
    end
    return 1;
  endfunction

  function automatic void refresh_marks();
    int nc, nr, ncon, nvar, rhs, first, nz, negrow, bs, bns;
    bit starred [0:31];
    bit neg;
    longint v, top;
    nc = eff_cols();
    nr = eff_rows();
    ncon = nr - 1;
    nvar = nc - 2;
    rhs = nc - 1;
    first = ncon;
    for (int k = 0; k < 1024; k++) mark_m[k] = MARK_NONE;
    for (int j = 0; j < 32; j++) starred[j] = 0;
    // a column with a single, negative, constraint entry stars that row
    for (int i = 0; i < nvar; i++) begin
      nz = 0;
      negrow = 0;
      neg = 0;
      for (int j = 0; j < ncon; j++) begin
        v = ent(j, i);
        if (v != 0) begin
          nz++;
          if (v < 0) begin
            negrow = j;
            neg = 1;
          end
        end
      end
      if (nz == 1 && neg) starred[negrow] = 1;
    end
    for (int j = ncon - 1; j >= 0; j--)
      if (starred[j]) first = j;

    if (first < ncon) begin
      // phase one: columns holding the starred row's largest positive entry
      top = 0;
      for (int i = 0; i < nvar; i++)
        if (ent(first, i) > top) top = ent(first, i);
      if (top <= 0) return;
      for (int i = 0; i < nvar; i++) begin
        if (ent(first, i) != top) continue;
        if (!min_ratio(i, ncon, rhs)) continue;
        bs = 0;
        bns = 0;
        for (int j = 0; j < ncon; j++) begin
          if (!tied_m[j]) continue;
          mark_m[j*DIM + i] = MARK_P1;
          if (starred[j]) bs++;
          else bns++;
        end
        // mixed tie: only the non-starred tied rows are demoted
        if (bs > 0 && bns > 0)
          for (int j = 0; j < ncon; j++)
            if (tied_m[j] && !starred[j]) mark_m[j*DIM + i] = MARK_P1_DEM;
      end
      return;
    end
    // phase two: negative objective entries
    for (int i = 0; i < nvar; i++) begin
      if (ent(ncon, i) >= 0) continue;
      if (!min_ratio(i, ncon, rhs)) continue;
      for (int j = 0; j < ncon; j++)
        if (tied_m[j]) mark_m[j*DIM + i] = MARK_P2;
    end
  endfunction

  function automatic bit apply_pivot(int r, int c);
    int nc, nr;
    longint p, m;
    nc = eff_cols();
    nr = eff_rows();
    p = ent(r, c);
    if (mag(p) <= longint'(eps_reg)) return 0;
    for (int i = 0; i < nc; i++)
      tab_m[r*DIM + i] = 32'(sat32(fx_divide(ent(r, i), p)));
    tab_m[r*DIM + c] = FX_ONE;
    for (int j = 0; j < nr; j++) begin
      if (j == r) continue;
      m = ent(j, c);
      for (int i = 0; i < nc; i++)
        tab_m[j*DIM + i] = 32'(sat32(ent(j, i) - fx_round_shift(m * ent(r, i))));
      tab_m[j*DIM + c] = '0;
    end
    return 1;
  endfunction

  // updates the model state and returns the response the block owes
  function automatic stp_rsp_t predict_rsp(stp_req_t t);
    stp_rsp_t o;
    int idx;
    idx = int'(t.row)*DIM + int'(t.col);
    o.status = 1'b0;
    if (t.cmd == CMD_WRITE) begin
      tab_m[idx] = t.value;
      refresh_marks();
    end else if (t.cmd == CMD_PIVOT) begin
      if (apply_pivot(int'(t.row), int'(t.col))) refresh_marks();
      else o.status = 1'b1;
    end
    o.read_value = tab_m[idx];
    o.mark = mark_m[idx];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stp_rsp_t e;
    if (!rst && done) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected result rv=%h mark=%0d st=%0b", $time,
                 rsp.read_value, rsp.mark, rsp.status);
        fail_cnt++;
      end else begin
        e = expected_rsp_q.pop_front();
        if (rsp.read_value !== e.read_value) begin
          $display("%0t: read_value exp %h got %h", $time, e.read_value, rsp.read_value);
          fail_cnt++;
        end
        if (rsp.mark !== e.mark) begin
          $display("%0t: mark exp %0d got %0d", $time, e.mark, rsp.mark);
          fail_cnt++;
        end
        if (rsp.status !== e.status) begin
          $display("%0t: status exp %0b got %0b", $time, e.status, rsp.status);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // one command transaction; a typed expectation overrides the model result
  task automatic send_cmd(stp_req_t t, bit typed, stp_rsp_t typed_rsp);
    stp_rsp_t p;
    bit idle_ok;
    // long stretch with no idling in the middle of the run
    idle_ok = !(sent_cnt >= 150 && sent_cnt < 330);
    if (idle_ok && $urandom_range(99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    req <= t;
    do @(posedge clk); while (busy);
    p = predict_rsp(t);
    expected_rsp_q.push_back(typed ? typed_rsp : p);
    sent_cnt++;
  endtask

  task automatic cmd(logic [1:0] c, int r, int col, logic [31:0] v);
    stp_req_t t;
    t.cmd = c;
    t.row = r[IDX_W-1:0];
    t.col = col[IDX_W-1:0];
    t.value = v;
    send_cmd(t, 1'b0, '0);
  endtask

  // drain all results, then one APB write (setup + access)
  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    start <= 1'b0;
    while (expected_rsp_q.size() != 0 || busy) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NUM_COLS:  cols_reg = v[5:0];
      REG_NUM_ROWS:  rows_reg = v[5:0];
      REG_PIVOT_EPS: eps_reg = v[16:0];
      default: ;
    endcase
    // bus left idle before the next access
    @(posedge clk);
  endtask

  function automatic logic [31:0] small_fx();
    int k;
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'd0;
      4:          return $urandom_range(32'h1FFFF);             // fractional
      5:          return -$urandom_range(32'h1FFFF);
      default: begin
        k = $urandom_range(12);
        return (k - 6) <<< FRAC_BITS;                            // small integers
      end
    endcase
  endfunction

  // directed table
  typedef struct {
    stp_req_t t;
    bit       typed;
    stp_rsp_t r;
  } dir_row_t;
  dir_row_t dir_tbl [$];

  function automatic void add_row(logic [1:0] c, int r, int col, logic [31:0] v,
                                  bit typed = 0, logic [31:0] rv = 0,
                                  logic [1:0] mk = MARK_NONE, bit st = 0);
    dir_row_t d;
    d.t.cmd = c;
    d.t.row = r[IDX_W-1:0];
    d.t.col = col[IDX_W-1:0];
    d.t.value = v;
    d.typed = typed;
    d.r.read_value = rv;
    d.r.mark = mk;
    d.r.status = st;
    dir_tbl.push_back(d);
  endfunction

  // random phase: fill the used region if asked, then pivots, reads, rewrites and noise
  task automatic run_phase(int nops, bit fill);
    int nc, nr, r, c, sel;
    nc = eff_cols();
    nr = eff_rows();
    if (fill)
      for (int j = 0; j < nr; j++)
        for (int i = 0; i < nc; i++) cmd(CMD_WRITE, j, i, small_fx());
    for (int n = 0; n < nops; n++) begin
      r = $urandom_range(nr - 1);
      c = $urandom_range(nc - 1);
      sel = $urandom_range(99);
      if (sel < 40)      cmd(CMD_PIVOT, r, c, $urandom);
      else if (sel < 60) cmd(CMD_READ, r, c, $urandom);
      else if (sel < 80) cmd(CMD_WRITE, r, c, small_fx());
      else if (sel < 88) cmd(CMD_WRITE, $urandom_range(31), $urandom_range(31), $urandom);
      else if (sel < 94) cmd(CMD_PIVOT, $urandom_range(31), $urandom_range(31), $urandom);
      else               cmd(CMD_SPARE, $urandom_range(31), $urandom_range(31), $urandom);
    end
  endtask

  initial begin
    int ph;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_cnt = 0;
    sent_cnt = 0;
    for (int k = 0; k < 1024; k++) begin
      tab_m[k] = '0;
      mark_m[k] = MARK_NONE;
    end
    cols_reg = 6'd18;
    rows_reg = 6'd9;
    eps_reg = 17'd7;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // row-memory clearing pass after reset
    do @(posedge clk); while (busy);

    // directed: reset contents, extremes, refusals, star tie, phase two, far pivot
    add_row(CMD_READ,  0, 0, 32'h0, 1, 32'h0, MARK_NONE, 0);
    add_row(CMD_PIVOT, 0, 0, 32'h0, 1, 32'h0, MARK_NONE, 1);      // zero pivot refused
    add_row(CMD_SPARE, 31, 31, 32'hFFFFFFFF, 1, 32'h0, MARK_NONE, 0);
    add_row(CMD_WRITE, 31, 31, 32'h80000000, 1, 32'h80000000, MARK_NONE, 0);
    add_row(CMD_WRITE, 0, 0, 32'h7FFFFFFF);
    add_row(CMD_WRITE, 0, 17, 32'h00020000);
    add_row(CMD_PIVOT, 0, 0, 32'h0);
    add_row(CMD_WRITE, 2, 1, 32'h7);
    add_row(CMD_PIVOT, 2, 1, 32'h0);                              // at epsilon: refused
    add_row(CMD_WRITE, 2, 1, 32'h8);
    add_row(CMD_PIVOT, 2, 1, 32'h0);                              // just above epsilon
    add_row(CMD_WRITE, 3, 3, 32'hFFFF0000);                       // star row 3
    add_row(CMD_WRITE, 3, 4, 32'h00020000);
    add_row(CMD_WRITE, 3, 17, 32'h00040000);
    add_row(CMD_WRITE, 4, 4, 32'h00010000);
    add_row(CMD_WRITE, 4, 17, 32'h00020000);                      // tie starred/non-starred
    add_row(CMD_READ,  4, 4, 32'h0);
    add_row(CMD_WRITE, 3, 3, 32'h0);
    add_row(CMD_WRITE, 8, 5, 32'hFFFF0000);                       // negative objective
    add_row(CMD_WRITE, 1, 5, 32'h00030000);
    add_row(CMD_PIVOT, 1, 5, 32'h0);
    add_row(CMD_WRITE, 20, 25, 32'h00020000);
    add_row(CMD_PIVOT, 20, 25, 32'h0);                            // outside used region
    add_row(CMD_WRITE, 0, 0, 32'h80000000);
    add_row(CMD_PIVOT, 0, 0, 32'h0);
    foreach (dir_tbl[k]) send_cmd(dir_tbl[k].t, dir_tbl[k].typed, dir_tbl[k].r);

    // largest sizes and out-of-range dimensions: few items, no full fill
    reg_write(REG_NUM_COLS, 32'd32);
    reg_write(REG_NUM_ROWS, 32'd32);
    reg_write(REG_PIVOT_EPS, 32'd0);
    run_phase(8, 0);
    reg_write(REG_NUM_COLS, 32'd63);
    reg_write(REG_NUM_ROWS, 32'd0);
    run_phase(6, 0);
    reg_write(REG_NUM_COLS, 32'd0);
    reg_write(REG_NUM_ROWS, 32'd63);
    reg_write(REG_PIVOT_EPS, 32'd65536);
    run_phase(6, 0);

    // pause until the block has drained everything
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);

    // bulk of the run: small tableaus, well-formed fill then random operations
    ph = 0;
    while (sent_cnt < ITEMS) begin
      case (ph % 4)
        0: begin
          reg_write(REG_NUM_COLS, 32'd3);
          reg_write(REG_NUM_ROWS, 32'd2);
          reg_write(REG_PIVOT_EPS, 32'd0);
        end
        1: begin
          reg_write(REG_NUM_COLS, $urandom_range(4, 8));
          reg_write(REG_NUM_ROWS, $urandom_range(3, 6));
          reg_write(REG_PIVOT_EPS, $urandom_range(65535));
        end
        2: begin
          reg_write(REG_NUM_COLS, $urandom_range(4, 7));
          reg_write(REG_NUM_ROWS, $urandom_range(3, 5));
          reg_write(REG_PIVOT_EPS, $urandom_range(1, 40));
        end
        default: begin
          reg_write(REG_NUM_COLS, $urandom_range(3, 6));
          reg_write(REG_NUM_ROWS, $urandom_range(2, 5));
          reg_write(REG_PIVOT_EPS, 32'd65536);
        end
      endcase
      run_phase(40, 1);
      ph++;
    end
    start <= 1'b0;

    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/stp_pkg.sv
rtl/core/stp_div.sv
rtl/core/stp_cell.sv
rtl/core/simplex_tableau_pivot.sv
tb/sv/tb_top.sv
